// ===== src/subrm_pkg.sv =====
package subrm_pkg;

    // widths of the string path
    localparam int PATTERN_MAX = 8;
    localparam int BYTE_W      = 8;
    localparam int PTR_W       = $clog2(PATTERN_MAX);
    localparam int CNT_W       = PTR_W + 1;
    localparam int PAT_W       = PATTERN_MAX * BYTE_W;
    localparam int LEN_W       = 4;
    localparam int ADDR_W      = 4;

    // register map, 8-byte spacing, selected by paddr[3]
    localparam logic REG_PATTERN_BYTES  = 1'b0;
    localparam logic REG_PATTERN_LENGTH = 1'b1;

    // input item kinds
    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_END  = 3'b100
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic drop_match;
        logic emit_front;
        logic emit_end;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full_match;
        logic prefix_ok;
        logic out_free;
    } dp_status_t;

endpackage

// ===== src/substring_remover_top.sv =====
// a data byte is taken while the controller is idle and then decided one step per cycle in
// the scan loop (one drop, emit or hold decision per cycle, an emit waiting while the output
// is stalled); a kept byte is registered in the output register before it appears; no new
// item is taken until the scan loop has returned to idle
// reset: aresetn synchronous active low; clears the held count, controller and output
// valid; pattern registers reset to zero (removal disabled); no clearing pass
module substring_remover_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // apb configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [subrm_pkg::ADDR_W-1:0]        paddr,
    input  logic [63:0]                         pwdata,
    output logic [63:0]                         prdata,
    output logic                                pready,
    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // data_byte
    input  logic                                s_tuser,   // command
    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // out_byte
    output logic                                m_tuser,   // has_byte
    output logic                                m_tlast    // string_end
);

    logic [subrm_pkg::PAT_W-1:0] pattern_bytes_reg;
    logic [subrm_pkg::LEN_W-1:0] pattern_length_reg;
    logic                        cfg_write;
    subrm_pkg::dp_cmd_t          cmd;
    subrm_pkg::dp_status_t       status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_bytes_reg  <= '0;
            pattern_length_reg <= '0;
        end else if (cfg_write) begin
            if (paddr[3] == subrm_pkg::REG_PATTERN_BYTES) begin
                pattern_bytes_reg <= pwdata;
            end else begin
                pattern_length_reg <= pwdata[subrm_pkg::LEN_W-1:0];
            end
        end
    end

    // register read back
    always_comb begin
        if (paddr[3] == subrm_pkg::REG_PATTERN_BYTES) begin
            prdata = pattern_bytes_reg;
        end else begin
            prdata = {{(64-subrm_pkg::LEN_W){1'b0}}, pattern_length_reg};
        end
    end

    subrm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    subrm_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .in_byte        (s_tdata),
        .pattern_bytes  (pattern_bytes_reg),
        .pattern_length (pattern_length_reg),
        .status         (status),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast)
    );

endmodule

// ===== src/subrm_dp.sv =====
module subrm_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  subrm_pkg::dp_cmd_t                   cmd,
    input  logic [subrm_pkg::BYTE_W-1:0]         in_byte,
    input  logic [subrm_pkg::PAT_W-1:0]          pattern_bytes,
    input  logic [subrm_pkg::LEN_W-1:0]          pattern_length,
    output subrm_pkg::dp_status_t                status,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [subrm_pkg::BYTE_W-1:0]         m_tdata,   // out_byte
    output logic                                 m_tuser,   // has_byte
    output logic                                 m_tlast    // string_end
);

    logic [subrm_pkg::BYTE_W-1:0] held_reg  [subrm_pkg::PATTERN_MAX];
    logic [subrm_pkg::BYTE_W-1:0] held_next [subrm_pkg::PATTERN_MAX];
    logic [subrm_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [subrm_pkg::CNT_W-1:0]  eff_len;
    logic [subrm_pkg::PATTERN_MAX-1:0] byte_match, len_mask, cnt_mask;
    logic [subrm_pkg::CNT_W-1:0]  src_idx [subrm_pkg::PATTERN_MAX];

    logic                         out_valid_reg, out_valid_next;
    logic [subrm_pkg::BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic                         out_has_reg, out_has_next;
    logic                         out_end_reg, out_end_next;

    // pattern length clipped to the held buffer depth
    always_comb begin
        if (pattern_length > subrm_pkg::LEN_W'(subrm_pkg::PATTERN_MAX)) begin
            eff_len = subrm_pkg::CNT_W'(subrm_pkg::PATTERN_MAX);
        end else begin
            eff_len = subrm_pkg::CNT_W'(pattern_length);
        end
    end

    // per-position compare of held bytes against the pattern
    always_comb begin
        for (int k = 0; k < subrm_pkg::PATTERN_MAX; k++) begin
            byte_match[k] = held_reg[k] == pattern_bytes[k*subrm_pkg::BYTE_W +: subrm_pkg::BYTE_W];
            len_mask[k]   = subrm_pkg::CNT_W'(k) < eff_len;
            cnt_mask[k]   = subrm_pkg::CNT_W'(k) < count_reg;
            src_idx[k]    = subrm_pkg::CNT_W'(k) + eff_len;
        end
    end

    // scan decisions
    assign status.empty      = count_reg == '0;
    assign status.full_match = (eff_len != '0) && (count_reg >= eff_len)
                               && (&(byte_match | ~len_mask));
    assign status.prefix_ok  = (eff_len != '0) && (count_reg < eff_len)
                               && (&(byte_match | ~cnt_mask));
    assign status.out_free   = !out_valid_reg || m_tready;

    // held buffer: append, drop a whole match, or drop the front byte
    always_comb begin
        held_next  = held_reg;
        count_next = count_reg;
        if (cmd.load) begin
            held_next[count_reg[subrm_pkg::PTR_W-1:0]] = in_byte;
            count_next = count_reg + 1'b1;
        end else if (cmd.drop_match) begin
            for (int k = 0; k < subrm_pkg::PATTERN_MAX; k++) begin
                if (!src_idx[k][subrm_pkg::PTR_W]) begin
                    held_next[k] = held_reg[src_idx[k][subrm_pkg::PTR_W-1:0]];
                end
            end
            count_next = count_reg - eff_len;
        end else if (cmd.emit_front) begin
            for (int k = 0; k < subrm_pkg::PATTERN_MAX - 1; k++) begin
                held_next[k] = held_reg[k+1];
            end
            count_next = count_reg - 1'b1;
        end
    end

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_has_next   = out_has_reg;
        out_end_next   = out_end_reg;
        if (cmd.emit_front) begin
            out_valid_next = 1'b1;
            out_byte_next  = held_reg[0];
            out_has_next   = 1'b1;
            out_end_next   = 1'b0;
        end else if (cmd.emit_end) begin
            out_valid_next = 1'b1;
            out_byte_next  = '0;
            out_has_next   = 1'b0;
            out_end_next   = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        held_reg     <= held_next;
        out_byte_reg <= out_byte_next;
        out_has_reg  <= out_has_next;
        out_end_reg  <= out_end_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_has_reg;
    assign m_tlast  = out_end_reg;

endmodule

// ===== src/subrm_ctrl.sv =====
module subrm_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tuser,    // command
    output logic                   s_tready,
    input  subrm_pkg::dp_status_t  status,
    output subrm_pkg::dp_cmd_t     cmd
);

    subrm_pkg::state_t state_reg, state_next;
    logic              at_end_reg, at_end_next;
    logic              accept;

    assign s_tready = state_reg == subrm_pkg::ST_IDLE;
    assign accept   = s_tvalid && s_tready;

    // one scan decision per cycle
    always_comb begin
        state_next     = state_reg;
        at_end_next    = at_end_reg;
        cmd            = '0;
        case (state_reg)
            subrm_pkg::ST_IDLE: begin
                if (accept) begin
                    at_end_next = s_tuser == subrm_pkg::CMD_END;
                    cmd.load    = s_tuser == subrm_pkg::CMD_DATA;
                    state_next  = subrm_pkg::ST_SCAN;
                end
            end
            subrm_pkg::ST_SCAN: begin
                if (status.empty) begin
                    state_next = at_end_reg ? subrm_pkg::ST_END : subrm_pkg::ST_IDLE;
                end else if (status.full_match) begin
                    cmd.drop_match = 1'b1;
                end else if (!at_end_reg && status.prefix_ok) begin
                    state_next = subrm_pkg::ST_IDLE;
                end else if (status.out_free) begin
                    cmd.emit_front = 1'b1;
                end
            end
            subrm_pkg::ST_END: begin
                if (status.out_free) begin
                    cmd.emit_end = 1'b1;
                    state_next   = subrm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = subrm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= subrm_pkg::ST_IDLE;
            at_end_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            at_end_reg <= at_end_next;
        end
    end

endmodule
